### sv/xor_fletcher_frame_deframer_unit_assert.svh
// ============================================================================
// Assertion macros for the frame deframer
// Clocked on i_clk, disabled while i_rst_n is low.
// ============================================================================
`ifndef XOR_FLETCHER_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define XOR_FLETCHER_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define XFFD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define XFFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/xffd_pkg.sv
// ============================================================================
// xffd_pkg
// Shared types, constants and helpers of the XOR / Fletcher-16 deframer.
// ============================================================================
package xffd_pkg;

    localparam int MAX_FRAME_BYTES        = 512;
    localparam int MAX_KEY_BYTES          = 32;
    localparam int HEADER_AND_CHECK_BYTES = 6;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 9;
    localparam int MAGIC_W   = 16;
    localparam int KLEN_W    = 6;
    localparam int KIDX_W    = 5;
    localparam int KEY_REGS  = 4;
    localparam int KREG_W    = 64;
    localparam int KEY_BITS  = KEY_REGS * KREG_W;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int REG_IDX_W = 3;
    localparam int POS_W     = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W     = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    localparam logic [POS_W-1:0]  POS_MAX      = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0]  POS_HUNT     = POS_W'(0);
    localparam logic [POS_W-1:0]  POS_MAGIC_LO = POS_W'(1);
    localparam logic [POS_W-1:0]  POS_HEADER   = POS_W'(2);
    localparam logic [POS_W-1:0]  POS_LEN_HI   = POS_W'(3);
    localparam logic [POS_W-1:0]  POS_LEN_LO   = POS_W'(4);
    localparam logic [KLEN_W-1:0] KEY_LEN_MAX  = KLEN_W'(MAX_KEY_BYTES);
    localparam logic [BYTE_W-1:0] SUM_MOD      = 8'hFF;

    // Register indexes (byte address = 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_MAGIC   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_PAY = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LEN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY0    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY1    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KEY2    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_KEY3    = 3'd6;

    localparam logic [LEN_W-1:0] MAX_PAY_RESET = 9'd256;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_BAD   = 2'd1,
        ST_ABORT = 2'd2
    } t_status;

    typedef struct packed {
        logic [MAGIC_W-1:0]  magic;
        logic [LEN_W-1:0]    max_payload;
        logic [KLEN_W-1:0]   key_length;
        logic [KEY_BITS-1:0] key;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        t_status           status;
        logic [LEN_W-1:0]  length;
        logic              last;
    } t_result;

    // (a + b) mod 255 for a below 255
    function automatic logic [BYTE_W-1:0] mod255_add(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, SUM_MOD}) begin
            sum = sum - {1'b0, SUM_MOD};
        end
        return sum[BYTE_W-1:0];
    endfunction

endpackage

### sv/xffd_regs.sv
// ============================================================================
// xffd_regs
// Configuration register file behind the APB-style port.
// ============================================================================
module xffd_regs
    import xffd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [MAGIC_W-1:0]              r_magic;
    logic [LEN_W-1:0]                r_max_pay;
    logic [KLEN_W-1:0]               r_key_len;
    logic [KEY_REGS-1:0][KREG_W-1:0] r_key;
    logic [REG_IDX_W-1:0]            reg_idx;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= '0;
            r_max_pay <= MAX_PAY_RESET;
            r_key_len <= '0;
            r_key     <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MAGIC:   r_magic   <= pwdata[MAGIC_W-1:0];
                REG_MAX_PAY: r_max_pay <= pwdata[LEN_W-1:0];
                REG_KEY_LEN: r_key_len <= pwdata[KLEN_W-1:0];
                REG_KEY0:    r_key[0]  <= pwdata;
                REG_KEY1:    r_key[1]  <= pwdata;
                REG_KEY2:    r_key[2]  <= pwdata;
                REG_KEY3:    r_key[3]  <= pwdata;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAGIC:   prdata = DATA_W'(r_magic);
            REG_MAX_PAY: prdata = DATA_W'(r_max_pay);
            REG_KEY_LEN: prdata = DATA_W'(r_key_len);
            REG_KEY0:    prdata = r_key[0];
            REG_KEY1:    prdata = r_key[1];
            REG_KEY2:    prdata = r_key[2];
            REG_KEY3:    prdata = r_key[3];
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.magic       = r_magic;
    assign o_cfg.max_payload = r_max_pay;
    assign o_cfg.key_length  = r_key_len;
    assign o_cfg.key         = r_key;

endmodule

### sv/xffd_core.sv
// ============================================================================
// xffd_core
// Frame state machine: marker hunt, length, XOR key stream and Fletcher-16.
// ============================================================================
`include "xor_fletcher_frame_deframer_unit_assert.svh"

module xffd_core
    import xffd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_res
);

    logic [POS_W-1:0]  r_pos,     n_pos;
    logic [BYTE_W-1:0] r_len_hi,  n_len_hi;
    logic [LEN_W-1:0]  r_len,     n_len;
    logic [KIDX_W-1:0] r_key_idx, n_key_idx;
    logic [BYTE_W-1:0] r_sum_lo,  n_sum_lo;
    logic [BYTE_W-1:0] r_sum_hi,  n_sum_hi;
    logic [BYTE_W-1:0] r_chk_hi,  n_chk_hi;

    logic [KLEN_W-1:0] klen;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] dec_byte;
    logic [KIDX_W-1:0] dec_idx;
    logic [POS_W-1:0]  pos_inc;
    logic [CMP_W-1:0]  pos_cmp;
    logic [CMP_W-1:0]  len_cmp;
    logic [BYTE_W-1:0] sum_lo_add;
    logic [BYTE_W-1:0] magic_hi;
    logic [BYTE_W-1:0] magic_lo;
    logic              chk_good;

    assign magic_hi = i_cfg.magic[MAGIC_W-1:BYTE_W];
    assign magic_lo = i_cfg.magic[BYTE_W-1:0];

    // Key stream: clamp length, pick byte, advance and wrap the index
    always_comb begin
        klen     = (i_cfg.key_length > KEY_LEN_MAX) ? KEY_LEN_MAX : i_cfg.key_length;
        key_byte = i_cfg.key[{r_key_idx, 3'b000} +: BYTE_W];
        if (klen == '0) begin
            dec_byte = i_byte;
            dec_idx  = r_key_idx;
        end else begin
            dec_byte = i_byte ^ key_byte;
            if (({1'b0, r_key_idx} + KLEN_W'(1)) >= klen) begin
                dec_idx = '0;
            end else begin
                dec_idx = r_key_idx + KIDX_W'(1);
            end
        end
    end

    assign pos_inc    = r_pos + POS_W'(1);
    assign pos_cmp    = CMP_W'(pos_inc);
    assign len_cmp    = CMP_W'(r_len);
    assign sum_lo_add = mod255_add(r_sum_lo, dec_byte);
    assign chk_good   = (r_chk_hi == r_sum_hi) && (dec_byte == r_sum_lo);

    always_comb begin
        n_pos     = r_pos;
        n_len_hi  = r_len_hi;
        n_len     = r_len;
        n_key_idx = r_key_idx;
        n_sum_lo  = r_sum_lo;
        n_sum_hi  = r_sum_hi;
        n_chk_hi  = r_chk_hi;
        o_res        = '0;
        o_res.kind   = KIND_PAYLOAD;
        o_res.status = ST_GOOD;
        o_res.length = r_len;
        if (i_go) begin
            priority if (r_pos == POS_HUNT) begin
                n_pos = (i_byte == magic_hi) ? POS_MAGIC_LO : POS_HUNT;
            end else if (r_pos == POS_MAGIC_LO) begin
                if (i_byte == magic_lo) begin
                    n_pos = POS_HEADER;
                end else begin
                    n_pos = (i_byte == magic_hi) ? POS_MAGIC_LO : POS_HUNT;
                end
            end else if (r_pos >= POS_MAX) begin
                n_pos        = POS_HUNT;
                o_res.valid  = 1'b1;
                o_res.kind   = KIND_END;
                o_res.status = ST_ABORT;
                o_res.last   = 1'b1;
            end else begin
                n_pos = pos_inc;
                priority if (pos_inc == POS_LEN_HI) begin
                    n_len_hi = i_byte;
                end else if (pos_inc == POS_LEN_LO) begin
                    n_len     = {r_len_hi[0], i_byte};
                    n_key_idx = '0;
                    n_sum_lo  = '0;
                    n_sum_hi  = '0;
                    n_chk_hi  = '0;
                    if ({r_len_hi, i_byte} > 16'(i_cfg.max_payload)) begin
                        n_pos = POS_HUNT;
                    end
                end else if (pos_cmp <= len_cmp + CMP_W'(HEADER_AND_CHECK_BYTES - 2)) begin
                    n_key_idx   = dec_idx;
                    n_sum_lo    = sum_lo_add;
                    n_sum_hi    = mod255_add(r_sum_hi, sum_lo_add);
                    o_res.valid = 1'b1;
                    o_res.data  = dec_byte;
                end else if (pos_cmp == len_cmp + CMP_W'(HEADER_AND_CHECK_BYTES - 1)) begin
                    n_key_idx = dec_idx;
                    n_chk_hi  = dec_byte;
                end else begin
                    n_key_idx    = dec_idx;
                    n_pos        = POS_HUNT;
                    o_res.valid  = 1'b1;
                    o_res.kind   = KIND_END;
                    o_res.status = chk_good ? ST_GOOD : ST_BAD;
                    o_res.last   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len_hi  <= '0;
            r_len     <= '0;
            r_key_idx <= '0;
            r_sum_lo  <= '0;
            r_sum_hi  <= '0;
            r_chk_hi  <= '0;
        end else begin
            r_pos     <= n_pos;
            r_len_hi  <= n_len_hi;
            r_len     <= n_len;
            r_key_idx <= n_key_idx;
            r_sum_lo  <= n_sum_lo;
            r_sum_hi  <= n_sum_hi;
            r_chk_hi  <= n_chk_hi;
        end
    end

    `XFFD_ASSERT_IMPL(a_pos_bound, 1'b1, r_pos <= POS_MAX, "byte position past frame store")
    `XFFD_ASSERT_IMPL(a_sum_mod, 1'b1, (r_sum_lo != SUM_MOD) && (r_sum_hi != SUM_MOD), "checksum not reduced mod 255")
    `XFFD_ASSERT_NEXT(a_end_rehunt, i_go && o_res.valid && o_res.last, r_pos == POS_HUNT, "no rehunt after end of frame")
    `XFFD_ASSERT_IMPL(a_payload_pos, i_go && o_res.valid && (o_res.kind == KIND_PAYLOAD), r_pos >= POS_LEN_LO, "payload word before header done")

endmodule

### sv/xor_fletcher_frame_deframer_unit.sv
// ============================================================================
// xor_fletcher_frame_deframer_unit
// Magic-word framed receiver with XOR descrambling and Fletcher-16 check.
// ============================================================================
// Path: an accepted byte loads the input register, passes through xffd_core,
//   and its result loads the result register that drives the result handshake.
// Throughput: 1 byte per cycle while the result slot is free; the frame state
//   (position, key index, sums) updates in one pass through xffd_core.
// Reset: synchronous, active low; clears frame state and both valid flags,
//   and returns registers to magic 0, max payload 256, key length 0, key 0.
module xor_fletcher_frame_deframer_unit
    import xffd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // receive word channel
    input  logic              i_rx_valid,
    output logic              o_rx_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // result word channel
    output logic              o_res_valid,
    input  logic              i_res_stall,
    output logic              o_result_kind,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [1:0]        o_frame_status,
    output logic [LEN_W-1:0]  o_payload_length,
    output logic              o_last_of_frame,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg              cfg;
    t_result           core_res;

    // Input register: one received word waiting for the core
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Result register: one finished word waiting for the consumer
    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              proc_go;
    logic              rx_accept;

    xffd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The result slot frees up when empty or when its word is taken now.
    assign out_free = !r_out_valid || !i_res_stall;

    // Advance the core only when a word is held and the slot can take a result;
    // the core may produce no result, but reserving the slot keeps this simple
    // and costs nothing in steady flow.
    assign proc_go = r_in_valid && out_free;

    // Stall upstream only while the held word cannot move on.
    assign o_rx_stall = r_in_valid && !out_free;
    assign rx_accept  = i_rx_valid && !o_rx_stall;

    xffd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (proc_go),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // Input register: refill whenever the held word leaves or the slot is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_rx_stall) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register: load on a produced result, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_go && core_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && core_res.valid) begin
            r_out <= core_res;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_payload_byte   = r_out.data;
    assign o_frame_status   = r_out.status;
    assign o_payload_length = r_out.length;
    assign o_last_of_frame  = r_out.last;

endmodule
